// ----- rtl/rmst_pkg.sv -----
// Shared types, constants and node merge logic for the range max/sum tree.
// No dependencies; used by rmst_engine and range_max_sum_monotonic_tree.
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

    localparam int ARRAY_SIZE = 1024;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 42;
    localparam int NODE_DEPTH = 2 * ARRAY_SIZE;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int SPAN_W     = NODE_AW + 1;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] mx;
        logic signed [SUM_W-1:0] sum;
        logic signed [VAL_W-1:0] first;
        logic signed [VAL_W-1:0] last;
        logic                    rising;
        logic                    falling;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    localparam node_t NODE_RESET = '{
        mx: '0, sum: '0, first: '0, last: '0, rising: 1'b1, falling: 1'b1
    };

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        last_index;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                    bad_span;
        logic                    non_increasing;
        logic                    non_decreasing;
        logic signed [SUM_W-1:0] span_sum;
        logic signed [VAL_W-1:0] span_max;
    } res_t;

    function automatic node_t node_merge(input node_t a, input node_t b);
        node_t r;
        r.mx      = (a.mx > b.mx) ? a.mx : b.mx;
        r.sum     = a.sum + b.sum;
        r.first   = a.first;
        r.last    = b.last;
        r.rising  = a.rising && b.rising && (a.last <= b.first);
        r.falling = a.falling && b.falling && (a.last >= b.first);
        return r;
    endfunction

    function automatic node_t node_leaf(input logic signed [VAL_W-1:0] v);
        node_t r;
        r.mx      = v;
        r.sum     = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
        r.first   = v;
        r.last    = v;
        r.rising  = 1'b1;
        r.falling = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rmst_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rmst_engine.sv -----
// Tree sequencer: clear pass, leaf-to-root update and bottom-up span query.
// Depends on rmst_pkg and rmst_ram.
`timescale 1ns / 1ps
`default_nettype none

module rmst_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire rmst_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output rmst_pkg::res_t     res
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ULEAF = 4'd2;
    localparam logic [3:0] S_UMRG  = 4'd3;
    localparam logic [3:0] S_QL    = 4'd4;
    localparam logic [3:0] S_QLD   = 4'd5;
    localparam logic [3:0] S_QR    = 4'd6;
    localparam logic [3:0] S_QRD   = 4'd7;
    localparam logic [3:0] S_QSH   = 4'd8;
    localparam logic [3:0] S_QFIN  = 4'd9;
    localparam logic [3:0] S_QOUT  = 4'd10;

    logic [3:0]                     state_reg, state_next;
    logic [rmst_pkg::NODE_AW-1:0]   clr_reg, clr_next;
    logic [rmst_pkg::NODE_AW-1:0]   node_reg, node_next;
    rmst_pkg::node_t                cur_reg, cur_next;
    logic [rmst_pkg::SPAN_W-1:0]    l_reg, l_next, r_reg, r_next;
    rmst_pkg::node_t                accl_reg, accl_next, accr_reg, accr_next;
    logic                           accl_vld_reg, accl_vld_next;
    logic                           accr_vld_reg, accr_vld_next;
    rmst_pkg::res_t                 res_reg, res_next;

    logic                           ram_we, ram_re;
    logic [rmst_pkg::NODE_AW-1:0]   ram_waddr, ram_raddr;
    rmst_pkg::node_t                ram_wdata, ram_rdata;

    logic [rmst_pkg::NODE_AW-1:0]   parent;
    rmst_pkg::node_t                merged;
    rmst_pkg::node_t                total;
    logic [rmst_pkg::SPAN_W-1:0]    r_dec;

    rmst_ram #(
        .WIDTH (rmst_pkg::NODE_W),
        .DEPTH (rmst_pkg::NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_QOUT);
    assign res       = res_reg;
    assign parent    = node_reg >> 1;
    assign r_dec     = r_reg - rmst_pkg::SPAN_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        accl_next     = accl_reg;
        accr_next     = accr_reg;
        accl_vld_next = accl_vld_reg;
        accr_vld_next = accr_vld_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = node_reg;
        ram_wdata     = cur_reg;
        ram_re        = 1'b0;
        ram_raddr     = node_reg ^ rmst_pkg::NODE_AW'(1);
        merged        = node_reg[0] ? rmst_pkg::node_merge(ram_rdata, cur_reg)
                                    : rmst_pkg::node_merge(cur_reg, ram_rdata);
        total         = (accl_vld_reg && accr_vld_reg)
                        ? rmst_pkg::node_merge(accl_reg, accr_reg)
                        : (accl_vld_reg ? accl_reg : accr_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = rmst_pkg::NODE_RESET;
                clr_next  = clr_reg + rmst_pkg::NODE_AW'(1);
                if (clr_reg == rmst_pkg::NODE_AW'(rmst_pkg::NODE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == rmst_pkg::ACT_UPDATE)
                    begin
                        cur_next   = rmst_pkg::node_leaf(req.write_value);
                        node_next  = rmst_pkg::NODE_AW'(rmst_pkg::ARRAY_SIZE)
                                     + rmst_pkg::NODE_AW'(req.first_index);
                        state_next = S_ULEAF;
                    end
                    else if (req.first_index > req.last_index)
                    begin
                        res_next          = '0;
                        res_next.bad_span = 1'b1;
                        state_next        = S_QOUT;
                    end
                    else
                    begin
                        l_next        = rmst_pkg::SPAN_W'(rmst_pkg::ARRAY_SIZE)
                                        + rmst_pkg::SPAN_W'(req.first_index);
                        r_next        = rmst_pkg::SPAN_W'(rmst_pkg::ARRAY_SIZE + 1)
                                        + rmst_pkg::SPAN_W'(req.last_index);
                        accl_vld_next = 1'b0;
                        accr_vld_next = 1'b0;
                        state_next    = S_QL;
                    end
                end
            end
            S_ULEAF:
            begin
                ram_we     = 1'b1;
                ram_re     = 1'b1;
                state_next = S_UMRG;
            end
            S_UMRG:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = merged;
                cur_next  = merged;
                node_next = parent;
                if (parent == rmst_pkg::NODE_AW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = parent ^ rmst_pkg::NODE_AW'(1);
                end
            end
            S_QL:
            begin
                if (l_reg[0])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = l_reg[rmst_pkg::NODE_AW-1:0];
                    state_next = S_QLD;
                end
                else
                begin
                    state_next = S_QR;
                end
            end
            S_QLD:
            begin
                accl_next     = accl_vld_reg ? rmst_pkg::node_merge(accl_reg, ram_rdata)
                                             : ram_rdata;
                accl_vld_next = 1'b1;
                l_next        = l_reg + rmst_pkg::SPAN_W'(1);
                state_next    = S_QR;
            end
            S_QR:
            begin
                if (r_reg[0])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_dec[rmst_pkg::NODE_AW-1:0];
                    r_next     = r_dec;
                    state_next = S_QRD;
                end
                else
                begin
                    state_next = S_QSH;
                end
            end
            S_QRD:
            begin
                accr_next     = accr_vld_reg ? rmst_pkg::node_merge(ram_rdata, accr_reg)
                                             : ram_rdata;
                accr_vld_next = 1'b1;
                state_next    = S_QSH;
            end
            S_QSH:
            begin
                l_next = l_reg >> 1;
                r_next = r_reg >> 1;
                if ((l_reg >> 1) < (r_reg >> 1))
                begin
                    state_next = S_QL;
                end
                else
                begin
                    state_next = S_QFIN;
                end
            end
            S_QFIN:
            begin
                res_next.bad_span       = 1'b0;
                res_next.non_increasing = total.falling;
                res_next.non_decreasing = total.rising;
                res_next.span_sum       = total.sum;
                res_next.span_max       = total.mx;
                state_next              = S_QOUT;
            end
            S_QOUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            accl_vld_reg <= 1'b0;
            accr_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            accl_vld_reg <= accl_vld_next;
            accr_vld_reg <= accr_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        accl_reg <= accl_next;
        accr_reg <= accr_next;
        res_reg  <= res_next;
    end

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("node read and write hit the same entry");

    a_no_root_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (ram_raddr != '0))
        else $error("read of unused node slot");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.bad_span) |-> (res.span_sum == '0 && res.span_max == '0))
        else $error("bad span result carries data");

    a_span_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QL) |-> (l_reg < r_reg))
        else $error("query walk on empty span");

endmodule

`default_nettype wire

// ----- rtl/range_max_sum_monotonic_tree.sv -----
// Top level: stream ports, result register and the tree engine.
// Depends on rmst_pkg, rmst_engine and rmst_ram.
//
// Usage:
//   Requests enter on s_axis; s_axis_tuser selects update (0) or query (1).
//   An update writes one position and returns nothing. A query returns one
//   result on m_axis with max, sum and both monotonic flags of the inclusive
//   span; m_axis_tuser flags a span whose first index exceeds its last.
//   Update: one leaf write plus one sibling read and parent write per tree
//   level; the next request is taken once the root has been written.
//   Query: a bad span gives its result with no node reads; otherwise each
//   tree level makes up to two node reads, one per side of the span,
//   through the single node RAM read port.
//   After reset the block clears all 2048 node entries, one per cycle,
//   with s_axis_tready low; the array then reads as all zeros.
//   A finished result waits in the output register while the receiver
//   stalls; a new request is taken meanwhile, but a later query holds its
//   result until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module range_max_sum_monotonic_tree (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_index[9:0], last_index[19:10], write_value[51:20], zero pad
    input  wire logic [55:0] s_axis_tdata,
    // action[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // span_max[31:0], span_sum[73:32], non_decreasing[74], non_increasing[75], zero pad
    output logic [79:0]      m_axis_tdata,
    // bad_span[0]
    output logic [0:0]       m_axis_tuser
);

    rmst_pkg::req_t req;
    rmst_pkg::res_t res;
    logic           res_valid, res_ready;
    logic           out_valid_reg, out_valid_next;
    rmst_pkg::res_t out_reg, out_next;

    assign req.action      = s_axis_tuser[0];
    assign req.first_index = s_axis_tdata[9:0];
    assign req.last_index  = s_axis_tdata[19:10];
    assign req.write_value = s_axis_tdata[51:20];

    rmst_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_reg.non_increasing, out_reg.non_decreasing,
                            out_reg.span_sum, out_reg.span_max};
    assign m_axis_tuser  = out_reg.bad_span;

endmodule

`default_nettype wire
